// ===== rtl/utf8nv_pkg.sv =====
// Shared types, constants and the helper function of the UTF-8 name validator.
`timescale 1ns / 1ps

package utf8nv_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SCALAR_W = 21;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [BYTE_W-1:0] MAX_NAME_RESET = 8'd64;
	localparam logic [BYTE_W-1:0] COUNT_SAT      = 8'hFF;

	// register index, taken from paddr above the byte offset
	localparam logic REG_MAX_NAME_BYTES = 1'b0;

	typedef enum logic [3:0] {
		FAULT_NONE       = 4'd0,
		FAULT_CONTROL    = 4'd1,
		FAULT_BAD_LEAD   = 4'd2,
		FAULT_BAD_CONT   = 4'd3,
		FAULT_TRUNCATED  = 4'd4,
		FAULT_OVERLONG   = 4'd5,
		FAULT_RANGE      = 4'd6,
		FAULT_SPACE_ONLY = 4'd7,
		FAULT_TOO_LONG   = 4'd8
	} fault_t;

	// per-name decoder state
	typedef struct packed {
		logic [1:0]          pend;
		logic [1:0]          seq_len;
		logic [SCALAR_W-1:0] acc;
		logic [BYTE_W-1:0]   count;
		logic                saw_non_space;
		fault_t              fault;
	} name_state_t;

	localparam name_state_t NAME_STATE_CLEAR = '{
		pend:          2'd0,
		seq_len:       2'd0,
		acc:           '0,
		count:         '0,
		saw_non_space: 1'b0,
		fault:         FAULT_NONE
	};

	// verdict of one finished name
	typedef struct packed {
		logic   ok;
		fault_t fault;
	} verdict_t;

	function automatic logic is_wide_space(input logic [SCALAR_W-1:0] s);
		logic r;
		r = (s == 21'h00085) || (s == 21'h000A0) || (s == 21'h01680) ||
			((s >= 21'h02000) && (s <= 21'h0200A)) ||
			(s == 21'h02028) || (s == 21'h02029) || (s == 21'h0202F) ||
			(s == 21'h0205F) || (s == 21'h03000);
		return r;
	endfunction

endpackage

// ===== rtl/utf8nv_apb.sv =====
// APB register slave holding the name length limit.
`timescale 1ns / 1ps

module utf8nv_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [utf8nv_pkg::PADDR_W-1:0]      paddr,
	input  logic [utf8nv_pkg::PDATA_W-1:0]      pwdata,
	output logic [utf8nv_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready,
	output logic [utf8nv_pkg::BYTE_W-1:0]       max_name_bytes
);

	logic                             hit;
	logic [utf8nv_pkg::BYTE_W-1:0]    max_q;

	assign hit    = (paddr[utf8nv_pkg::PADDR_W-1] == utf8nv_pkg::REG_MAX_NAME_BYTES);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= utf8nv_pkg::MAX_NAME_RESET;
		end else if (psel && penable && pwrite && hit) begin
			max_q <= pwdata[utf8nv_pkg::BYTE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[utf8nv_pkg::BYTE_W-1:0] = max_q;
		end
	end

	assign max_name_bytes = max_q;

endmodule

// ===== rtl/utf8nv_decode.sv =====
// Next-state and verdict logic for one byte of a name.
`timescale 1ns / 1ps

module utf8nv_decode (
	input  utf8nv_pkg::name_state_t          cur,
	input  logic [utf8nv_pkg::BYTE_W-1:0]    b,
	input  logic [utf8nv_pkg::BYTE_W-1:0]    max_name_bytes,
	output utf8nv_pkg::name_state_t          nxt,
	output utf8nv_pkg::verdict_t             verdict
);

	logic [utf8nv_pkg::BYTE_W:0]       pos;
	logic [utf8nv_pkg::SCALAR_W-1:0]   acc_new;
	logic [1:0]                        pend_new;
	logic [utf8nv_pkg::SCALAR_W-1:0]   least;
	utf8nv_pkg::fault_t                v;

	always_comb begin
		nxt      = cur;
		pos      = {1'b0, cur.count} + 9'd1;
		acc_new  = {cur.acc[utf8nv_pkg::SCALAR_W-7:0], b[5:0]};
		pend_new = 2'(cur.pend - 2'd1);
		case (cur.seq_len)
			2'd1:    least = 21'h00080;
			2'd2:    least = 21'h00800;
			default: least = 21'h10000;
		endcase

		if (pos > {1'b0, max_name_bytes}) begin
			nxt.fault = utf8nv_pkg::FAULT_TOO_LONG;
		end
		if (cur.count != utf8nv_pkg::COUNT_SAT) begin
			nxt.count = 8'(cur.count + 8'd1);
		end

		// once any fault is held, bytes are only counted and checked against the length limit
		if (nxt.fault == utf8nv_pkg::FAULT_NONE) begin
			if (cur.pend != 2'd0) begin
				if (b[7:6] != 2'b10) begin
					nxt.fault = utf8nv_pkg::FAULT_BAD_CONT;
				end else begin
					nxt.acc  = acc_new;
					nxt.pend = pend_new;
					if (pend_new == 2'd0) begin
						if (acc_new < least) begin
							nxt.fault = utf8nv_pkg::FAULT_OVERLONG;
						end else if ((acc_new > 21'h10FFFF) ||
								((acc_new >= 21'h0D800) && (acc_new <= 21'h0DFFF))) begin
							nxt.fault = utf8nv_pkg::FAULT_RANGE;
						end else if (!utf8nv_pkg::is_wide_space(acc_new)) begin
							nxt.saw_non_space = 1'b1;
						end
					end
				end
			end else if (!b[7]) begin
				if ((b < 8'h20) || (b == 8'h7F)) begin
					nxt.fault = utf8nv_pkg::FAULT_CONTROL;
				end else if (b != 8'h20) begin
					nxt.saw_non_space = 1'b1;
				end
			end else if (b inside {[8'hC2:8'hDF]}) begin
				nxt.seq_len = 2'd1;
				nxt.pend    = 2'd1;
				nxt.acc     = {16'd0, b[4:0]};
			end else if (b inside {[8'hE0:8'hEF]}) begin
				nxt.seq_len = 2'd2;
				nxt.pend    = 2'd2;
				nxt.acc     = {17'd0, b[3:0]};
			end else if (b inside {[8'hF0:8'hF4]}) begin
				nxt.seq_len = 2'd3;
				nxt.pend    = 2'd3;
				nxt.acc     = {18'd0, b[2:0]};
			end else begin
				nxt.fault = utf8nv_pkg::FAULT_BAD_LEAD;
			end
		end

		// too long beats the first fault, then truncation, then whitespace only
		v = nxt.fault;
		if ((v == utf8nv_pkg::FAULT_NONE) && (nxt.pend != 2'd0)) begin
			v = utf8nv_pkg::FAULT_TRUNCATED;
		end
		if ((v == utf8nv_pkg::FAULT_NONE) && !nxt.saw_non_space) begin
			v = utf8nv_pkg::FAULT_SPACE_ONLY;
		end
		verdict.ok    = (v == utf8nv_pkg::FAULT_NONE);
		verdict.fault = v;
	end

endmodule

// ===== rtl/utf8_name_validator.sv =====
// Top level of the streaming UTF-8 display name validator.
`timescale 1ns / 1ps

// Takes one byte of a name per cycle while in_ready is high, flagged on its
// last byte, and checks it as strict UTF-8 with a whitespace-only check and a
// length limit (max_name_bytes, APB register at address 0, reset 64). A
// transaction on the input channel can complete every such cycle; each byte is
// registered, then folded into the per-name state by one pass of the byte
// decoder. The verdict is loaded into the output register when the last byte
// leaves the input register, which waits for a free output register. Only the
// last byte of a name yields an output transaction; the input keeps flowing
// while a verdict waits, until a second last byte reaches the input register
// behind it. Per-name state clears after every verdict.

module utf8_name_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [utf8nv_pkg::PADDR_W-1:0]      paddr,
	input  logic [utf8nv_pkg::PDATA_W-1:0]      pwdata,
	output logic [utf8nv_pkg::PDATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          name_byte,
	input  logic                                last_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                name_valid,
	output logic [3:0]                          fault_kind
);

	logic [utf8nv_pkg::BYTE_W-1:0]   max_name_bytes;
	logic                            valid_s1;
	logic [utf8nv_pkg::BYTE_W-1:0]   byte_s1;
	logic                            last_s1;
	logic                            advance;
	utf8nv_pkg::name_state_t         state_q;
	utf8nv_pkg::name_state_t         state_nxt;
	utf8nv_pkg::verdict_t            verdict;
	logic                            out_valid_q;
	logic                            name_valid_q;
	logic [3:0]                      fault_kind_q;

	utf8nv_apb u_apb (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.max_name_bytes (max_name_bytes)
	);

	utf8nv_decode u_decode (
		.cur            (state_q),
		.b              (byte_s1),
		.max_name_bytes (max_name_bytes),
		.nxt            (state_nxt),
		.verdict        (verdict)
	);

	// a non-final byte never needs the output register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= name_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utf8nv_pkg::NAME_STATE_CLEAR;
		end else if (advance) begin
			state_q <= last_s1 ? utf8nv_pkg::NAME_STATE_CLEAR : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			name_valid_q <= verdict.ok;
			fault_kind_q <= 4'(verdict.fault);
		end
	end

	assign out_valid  = out_valid_q;
	assign name_valid = name_valid_q;
	assign fault_kind = fault_kind_q;

endmodule
